// ===== src/size_class_block_cache_assert.svh =====
// ----------------------------------------------------------------------------
// Size-class block cache assertion macros
// Shared assertion wrappers, clocked on clk_i; SCBC_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BLOCK_CACHE_ASSERT_SVH
`define SIZE_CLASS_BLOCK_CACHE_ASSERT_SVH

// Check a property outside reset.
`define SCBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SCBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/scbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Size-class block cache package
// Payload structs, control structs and codes shared by the block's modules.
// ----------------------------------------------------------------------------
package scbc_pkg;

  localparam int unsigned PtrBits = 48;
  localparam int unsigned IncrBits = 32;
  localparam int unsigned BytesBits = 44;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [2:0] ST_REUSED   = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_CACHED   = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_ZERO_ERR = 3'd4;
  localparam logic [2:0] ST_OVER_ERR = 3'd5;

  typedef struct packed {
    logic                 func;
    logic [BytesBits-1:0] request_bytes;
    logic [PtrBits-1:0]   block_address;
    logic [IncrBits-1:0]  block_size_incr;
  } scbc_req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [PtrBits-1:0]  granted_address;
    logic [IncrBits-1:0] new_block_incr;
    logic                release_valid;
    logic [PtrBits-1:0]  release_base_address;
    logic [IncrBits-1:0] release_incr;
  } scbc_rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } scbc_cmd_t;

  typedef struct packed {
    logic out_free;
  } scbc_sts_t;

endpackage

// ===== src/scbc_ram.sv =====
// ----------------------------------------------------------------------------
// Size-class block cache RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/scbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Size-class block cache controller
// Two-state sequencer: take a request, then commit it once the output is free.
// ----------------------------------------------------------------------------
module scbc_ctrl
  import scbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  scbc_sts_t sts_i,
  output scbc_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  assign in_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit   = (state_q == S_EXEC) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/scbc_dp.sv =====
// ----------------------------------------------------------------------------
// Size-class block cache datapath
// Unit rounding, class row read-modify-write, fill counts and result register.
// ----------------------------------------------------------------------------
`include "size_class_block_cache_assert.svh"

module scbc_dp
  import scbc_pkg::*;
#(
  parameter int unsigned SIZE_CLASSES    = 16,
  parameter int unsigned SLOTS_PER_CLASS = 3,
  parameter int unsigned ALIGN_SHIFT     = 12,
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned ADDR_BITS       = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scbc_req_t  req_i,
  input  scbc_cmd_t  cmd_i,
  output scbc_sts_t  sts_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output scbc_rsp_t  rsp_o
);

  localparam int unsigned CW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int unsigned FW = $clog2(SLOTS_PER_CLASS + 1);
  localparam int unsigned IW = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int unsigned RW = SLOTS_PER_CLASS * PtrBits;
  localparam int unsigned SW = BytesBits + 1;
  localparam logic [PtrBits-1:0] AddrMask =
    (ADDR_BITS >= PtrBits) ? {PtrBits{1'b1}} : ((PtrBits'(1) << ADDR_BITS) - PtrBits'(1));

  logic [1:0]          limit_q;
  logic [FW-1:0]       fill_q [SIZE_CLASSES];
  logic                func_q, over_q, inrange_q;
  logic [IncrBits-1:0] incr_q;
  logic [PtrBits-1:0]  addr_q;
  logic [CW-1:0]       cls_q;
  logic                out_valid_q;
  scbc_rsp_t           rsp_q, rsp_d;

  // Request decode
  logic [SW-1:0]       sum, units;
  logic [IncrBits-1:0] incr_in;
  logic                over_in, inrange_in;
  logic [CW-1:0]       cls_in;

  always_comb begin
    sum        = {1'b0, req_i.request_bytes} + SW'(HEADER_BYTES);
    units      = (sum >> ALIGN_SHIFT) + SW'(|sum[ALIGN_SHIFT-1:0]);
    over_in    = (req_i.func == FUNC_ALLOC) && (|units[SW-1:IncrBits]);
    incr_in    = (req_i.func == FUNC_ALLOC) ? units[IncrBits-1:0] : req_i.block_size_incr;
    inrange_in = (incr_in != '0) && (incr_in <= IncrBits'(SIZE_CLASSES)) && !over_in;
    cls_in     = CW'(incr_in - IncrBits'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= req_i.func;
      over_q    <= over_in;
      inrange_q <= inrange_in;
      incr_q    <= incr_in;
      addr_q    <= req_i.block_address & AddrMask;
      cls_q     <= cls_in;
    end
  end

  // Class row store
  logic [RW-1:0]      row_rd, row_wr;
  logic               row_we;
  logic [PtrBits-1:0] slot [SLOTS_PER_CLASS];

  scbc_ram #(.Width(RW), .Depth(SIZE_CLASSES)) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (cls_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.capture),
    .raddr_i (cls_in),
    .rdata_o (row_rd)
  );

  // Execute
  logic [FW-1:0]      n, fill_new;
  logic [3:0]         n4, lim4;
  logic               evict, fill_we;
  logic [PtrBits-1:0] rel_ptr;

  always_comb begin
    for (int k = 0; k < SLOTS_PER_CLASS; k++) begin
      slot[k] = row_rd[k*PtrBits +: PtrBits];
    end
    n     = fill_q[cls_q];
    n4    = 4'(n);
    lim4  = (limit_q == 2'd0) ? 4'd1 : 4'(limit_q);
    if (lim4 > 4'(SLOTS_PER_CLASS)) lim4 = 4'(SLOTS_PER_CLASS);
    evict   = (n4 >= lim4);
    rel_ptr = slot[IW'(n - FW'(1))];

    row_wr   = row_rd;
    row_we   = 1'b0;
    fill_we  = 1'b0;
    fill_new = n;
    rsp_d    = '0;

    if (func_q == FUNC_ALLOC) begin
      if (over_q) begin
        rsp_d.status = ST_OVER_ERR;
      end else if (inrange_q && (n != '0)) begin
        // Pop the newest entry, advance the rest toward the head.
        rsp_d.status          = ST_REUSED;
        rsp_d.granted_address = slot[0];
        for (int k = 0; k < SLOTS_PER_CLASS; k++) begin
          row_wr[k*PtrBits +: PtrBits] =
            (k + 1 < SLOTS_PER_CLASS) ? slot[(k + 1) % SLOTS_PER_CLASS] : '0;
        end
        row_we   = 1'b1;
        fill_we  = 1'b1;
        fill_new = n - FW'(1);
      end else begin
        rsp_d.status         = ST_NEW;
        rsp_d.new_block_incr = incr_q;
      end
    end else begin
      if (incr_q == '0) begin
        rsp_d.status = ST_ZERO_ERR;
      end else if (!inrange_q) begin
        rsp_d.status               = ST_RELEASED;
        rsp_d.release_valid        = 1'b1;
        rsp_d.release_base_address = (addr_q - PtrBits'(HEADER_BYTES)) & AddrMask;
        rsp_d.release_incr         = incr_q;
      end else begin
        // Drop the stalest entry of a full class, then push at the head.
        rsp_d.status = ST_CACHED;
        if (evict) begin
          rsp_d.release_valid        = 1'b1;
          rsp_d.release_base_address = (rel_ptr - PtrBits'(HEADER_BYTES)) & AddrMask;
          rsp_d.release_incr         = incr_q;
        end
        row_wr[PtrBits-1:0] = addr_q;
        for (int k = 1; k < SLOTS_PER_CLASS; k++) begin
          row_wr[k*PtrBits +: PtrBits] = slot[k-1];
        end
        row_we   = 1'b1;
        fill_we  = 1'b1;
        fill_new = evict ? n : n + FW'(1);
      end
    end
    row_we  = row_we && cmd_i.commit;
    fill_we = fill_we && cmd_i.commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= 2'd3;
      out_valid_q <= 1'b0;
      for (int c = 0; c < SIZE_CLASSES; c++) fill_q[c] <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (fill_we) fill_q[cls_q] <= fill_new;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign rsp_o          = rsp_q;

  `SCBC_ASSERT(a_fill_bound, fill_we |-> (fill_new <= FW'(SLOTS_PER_CLASS)),
               "class fill above slot count")
  `SCBC_ASSERT(a_commit_shows, cmd_i.commit |=> out_valid_q, "committed result not presented")
  `SCBC_ASSERT(a_commit_free, !(cmd_i.commit && out_valid_q && !out_ready_i),
               "result overwritten while held")

endmodule

// ===== src/size_class_block_cache.sv =====
// ----------------------------------------------------------------------------
// Size-class block cache
// Segregated free-list cache of freed large blocks, one row per size class.
// ----------------------------------------------------------------------------
// Each request passes two states: accept reads the class row from the row RAM,
// and commit, once the output register is free, rewrites that row and the class
// fill count and loads the result register. A request is taken again once the
// result has been moved into the output register, so a stalled consumer holds
// the input side off only while a finished result is still waiting. An allocate
// request rounds bytes plus header up to alignment units; a cached block of
// that class is handed back newest first, otherwise the units to obtain are
// reported (an error if they overflow). A free caches the block, releasing the
// stalest one first when the class is full, or releases it straight away when
// its class lies above the cached range. The user must write the per-class
// limit through cfg_we_i and cfg_data_i only while idle; this is not enforced.
// ----------------------------------------------------------------------------
`include "size_class_block_cache_assert.svh"

module size_class_block_cache
  import scbc_pkg::*;
#(
  parameter int unsigned SIZE_CLASSES    = 16,
  parameter int unsigned SLOTS_PER_CLASS = 3,
  parameter int unsigned ALIGN_SHIFT     = 12,
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned ADDR_BITS       = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  scbc_req_t  in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output scbc_rsp_t  out_rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i
);

  scbc_cmd_t cmd;
  scbc_sts_t sts;

  // Sequence each request: capture and read, then commit.
  scbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the class rows, fill counts, limit register and result register.
  scbc_dp #(
    .SIZE_CLASSES    (SIZE_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .ALIGN_SHIFT     (ALIGN_SHIFT),
    .HEADER_BYTES    (HEADER_BYTES),
    .ADDR_BITS       (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (out_rsp_o)
  );

  // A taken request blocks the next one until it has been committed.
  `SCBC_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o,
               "request taken while one is in flight")
  // Commit and capture never share a cycle.
  `SCBC_ASSERT_ALWAYS(a_cmd_excl, !(cmd.capture && cmd.commit), "capture during commit")

endmodule
